// File: hw/rtl/multichannel_packet_reorder_buffer_defines.svh
// Assertion helpers for the reorder buffer.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef MULTICHANNEL_PACKET_REORDER_BUFFER_DEFINES_SVH
`define MULTICHANNEL_PACKET_REORDER_BUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPRB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mprb_pkg.sv
`timescale 1ns / 1ps
package mprb_pkg;

    typedef enum logic [1:0] {
        CMD_RECV  = 2'd0,
        CMD_DRAIN = 2'd1,
        CMD_SEND  = 2'd2,
        CMD_CLOSE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_DELIVERED = 3'd0,
        KIND_BUFFERED  = 3'd1,
        KIND_OLD_DUP   = 3'd2,
        KIND_DUP       = 3'd3,
        KIND_BEYOND    = 3'd4,
        KIND_DRAIN     = 3'd5,
        KIND_ASSIGNED  = 3'd6,
        KIND_CLOSED    = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_CHRD,
        S_SLRD,
        S_REL,
        S_FIN,
        S_DONE
    } t_state;

    // Most packets released by one command.
    localparam logic [4:0] MAX_RELEASE = 5'd16;

endpackage

// File: hw/rtl/mprb_ram.sv
`timescale 1ns / 1ps
// Simple dual-port memory: one write port, one read port, registered read data.
module mprb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/multichannel_packet_reorder_buffer.sv
`timescale 1ns / 1ps
// Multichannel receive reorder buffer with transmit sequence numbering.
//
// One command channel: a beat is taken at a rising edge where start is high and
// busy is low. The command selects receive, drain, send (assign a transmit
// sequence number) or close for one channel. Each command produces one or more
// result beats on the o_ ports, each marked by o_valid for exactly one cycle;
// o_last flags the final beat of a command. The receiver cannot stall, so
// results go out as soon as they are known and busy alone paces the block.
//
// Timing: send, close, old-duplicate and beyond-window commands are decided from
// the channel-state read alone. A receive that only buffers or hits a duplicate
// also needs the slot read-modify-write after the channel-state read. A run of
// packets goes out one beat per cycle. Each result is registered and appears in
// the cycle after the cycle that decides it.
//
// Reset: after i_rst_n is released the block sweeps both memories with busy
// high, clearing all slot valid bits and every channel's sequence numbers,
// window base and close flag.
`include "multichannel_packet_reorder_buffer_defines.svh"
module multichannel_packet_reorder_buffer
    import mprb_pkg::*;
#(
    parameter int WINDOW   = 16,
    parameter int CHANNELS = 8,
    parameter int TAG_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_channel,
    input  logic [31:0] i_seq_number,
    input  logic [15:0] i_payload_tag,
    input  logic [4:0]  i_budget,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_out_channel,
    output logic [31:0] o_out_seq,
    output logic [15:0] o_out_tag,
    output logic        o_last
);

    localparam int SLOTS = CHANNELS * WINDOW;
    localparam int WB    = $clog2(WINDOW);
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SA    = $clog2(SLOTS);
    localparam int TW    = (TAG_BITS < 16) ? TAG_BITS : 16;

    // Per-channel state, kept as one word of the channel memory.
    typedef struct packed {
        logic [31:0]   exp;
        logic [31:0]   tx;
        logic          closed;
        logic [WB-1:0] base;
    } t_chan;

    // Slot memory word.
    typedef struct packed {
        logic          valid;
        logic [TW-1:0] tag;
    } t_slot;

    // Channel index reduced modulo CHANNELS by repeated subtraction.
    function automatic logic [2:0] f_chan(input logic [2:0] c);
        logic [8:0] v;
        v = 9'(c);
        for (int i = 0; i < 8; i++) begin
            if (v >= 9'(CHANNELS)) begin
                v = v - 9'(CHANNELS);
            end
        end
        return v[2:0];
    endfunction

    function automatic logic [WB-1:0] f_wrap(input logic [WB:0] s);
        logic [WB:0] r;
        r = s;
        if (s >= (WB+1)'(WINDOW)) begin
            r = s - (WB+1)'(WINDOW);
        end
        return r[WB-1:0];
    endfunction

    function automatic logic [WB-1:0] f_inc(input logic [WB-1:0] b);
        return f_wrap((WB+1)'(b) + (WB+1)'(1));
    endfunction

    function automatic logic [SA-1:0] f_addr(input logic [CW-1:0] ch, input logic [WB-1:0] sl);
        return SA'(ch) * SA'(WINDOW) + SA'(sl);
    endfunction

    // Control registers.
    t_state         r_state, n_state;
    logic [SA-1:0]  r_clr, n_clr;
    logic           r_hold_v, n_hold_v;
    logic           r_o_valid, n_o_valid;

    // Item and working registers.
    t_cmd           r_cmd, n_cmd;
    logic [2:0]     r_ch3, n_ch3;
    logic [31:0]    r_seq, n_seq;
    logic [TW-1:0]  r_tag, n_tag;
    logic [4:0]     r_limit, n_limit;
    logic [4:0]     r_cnt, n_cnt;
    logic [WB-1:0]  r_slot, n_slot;
    logic           r_off_zero, n_off_zero;
    t_chan          r_cs, n_cs;
    logic [31:0]    r_hold_seq, n_hold_seq;
    logic [TW-1:0]  r_hold_tag, n_hold_tag;
    t_kind          r_o_kind, n_o_kind;
    logic [2:0]     r_o_ch, n_o_ch;
    logic [31:0]    r_o_seq, n_o_seq;
    logic [15:0]    r_o_tag, n_o_tag;
    logic           r_o_last, n_o_last;

    // Memory ports.
    logic           ch_we;
    logic [CW-1:0]  ch_wa, ch_ra;
    t_chan          ch_wd, ch_rd;
    logic           sl_we;
    logic [SA-1:0]  sl_wa, sl_ra;
    t_slot          sl_wd, sl_rd;

    logic [CW-1:0]  cur_ch;
    logic [31:0]    off;
    logic [2:0]     in_ch3;

    assign cur_ch = CW'(r_ch3);
    assign in_ch3 = f_chan(i_channel);
    assign off    = r_seq - ch_rd.exp;

    mprb_ram #(
        .WIDTH ($bits(t_chan)),
        .DEPTH (CHANNELS),
        .AW    (CW)
    ) u_chan_ram (
        .i_clk   (i_clk),
        .i_we    (ch_we),
        .i_waddr (ch_wa),
        .i_wdata (ch_wd),
        .i_raddr (ch_ra),
        .o_rdata (ch_rd)
    );

    mprb_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (SLOTS),
        .AW    (SA)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (sl_we),
        .i_waddr (sl_wa),
        .i_wdata (sl_wd),
        .i_raddr (sl_ra),
        .o_rdata (sl_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_hold_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_hold_v  <= n_hold_v;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ch3      <= n_ch3;
        r_seq      <= n_seq;
        r_tag      <= n_tag;
        r_limit    <= n_limit;
        r_cnt      <= n_cnt;
        r_slot     <= n_slot;
        r_off_zero <= n_off_zero;
        r_cs       <= n_cs;
        r_hold_seq <= n_hold_seq;
        r_hold_tag <= n_hold_tag;
        r_o_kind   <= n_o_kind;
        r_o_ch     <= n_o_ch;
        r_o_seq    <= n_o_seq;
        r_o_tag    <= n_o_tag;
        r_o_last   <= n_o_last;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_hold_v   = r_hold_v;
        n_cmd      = r_cmd;
        n_ch3      = r_ch3;
        n_seq      = r_seq;
        n_tag      = r_tag;
        n_limit    = r_limit;
        n_cnt      = r_cnt;
        n_slot     = r_slot;
        n_off_zero = r_off_zero;
        n_cs       = r_cs;
        n_hold_seq = r_hold_seq;
        n_hold_tag = r_hold_tag;

        // Result beat defaults: nothing goes out this cycle.
        n_o_valid  = 1'b0;
        n_o_kind   = r_o_kind;
        n_o_ch     = r_ch3;
        n_o_seq    = r_o_seq;
        n_o_tag    = r_o_tag;
        n_o_last   = 1'b0;

        ch_we = 1'b0;
        ch_wa = cur_ch;
        ch_wd = r_cs;
        ch_ra = cur_ch;
        sl_we = 1'b0;
        sl_wa = f_addr(cur_ch, r_cs.base);
        sl_wd = '{valid: 1'b0, tag: r_tag};
        sl_ra = f_addr(cur_ch, r_cs.base);

        unique case (r_state)
            S_CLR: begin
                // Post-reset sweep over every slot; the channel words ride along.
                sl_we = 1'b1;
                sl_wa = r_clr;
                sl_wd = '0;
                ch_wa = CW'(r_clr);
                ch_wd = '0;
                ch_we = (r_clr < SA'(CHANNELS));
                if (r_clr == SA'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + SA'(1);
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_cmd   = t_cmd'(i_command);
                    n_ch3   = in_ch3;
                    n_seq   = i_seq_number;
                    n_tag   = i_payload_tag[TW-1:0];
                    n_limit = (i_budget > MAX_RELEASE) ? MAX_RELEASE : i_budget;
                    ch_ra   = CW'(in_ch3);
                    n_state = S_CHRD;
                end
            end

            S_CHRD: begin
                // Channel word is on the read port now.
                n_cs = ch_rd;
                unique case (r_cmd)
                    CMD_RECV: begin
                        if (off[31]) begin
                            n_o_valid = 1'b1;
                            n_o_kind  = KIND_OLD_DUP;
                            n_o_seq   = r_seq;
                            n_o_tag   = 16'(r_tag);
                            n_o_last  = 1'b1;
                            n_state   = S_IDLE;
                        end else if (off >= 32'(WINDOW)) begin
                            n_o_valid = 1'b1;
                            n_o_kind  = KIND_BEYOND;
                            n_o_seq   = r_seq;
                            n_o_tag   = 16'(r_tag);
                            n_o_last  = 1'b1;
                            n_state   = S_IDLE;
                        end else begin
                            n_slot     = f_wrap((WB+1)'(ch_rd.base) + (WB+1)'(off[WB-1:0]));
                            n_off_zero = (off == 32'd0);
                            sl_ra      = f_addr(cur_ch, n_slot);
                            n_state    = S_SLRD;
                        end
                    end
                    CMD_DRAIN: begin
                        n_cnt = '0;
                        if (!ch_rd.closed && r_limit != 5'd0) begin
                            sl_ra   = f_addr(cur_ch, ch_rd.base);
                            n_state = S_REL;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    CMD_SEND: begin
                        n_o_valid = 1'b1;
                        n_o_tag   = '0;
                        n_o_last  = 1'b1;
                        if (ch_rd.closed) begin
                            n_o_kind = KIND_CLOSED;
                            n_o_seq  = '0;
                        end else begin
                            n_o_kind = KIND_ASSIGNED;
                            n_o_seq  = ch_rd.tx;
                            ch_we    = 1'b1;
                            ch_wd    = ch_rd;
                            ch_wd.tx = ch_rd.tx + 32'd1;
                        end
                        n_state = S_IDLE;
                    end
                    CMD_CLOSE: begin
                        ch_we        = 1'b1;
                        ch_wd        = ch_rd;
                        ch_wd.closed = 1'b1;
                        n_o_valid    = 1'b1;
                        n_o_kind     = KIND_CLOSED;
                        n_o_seq      = '0;
                        n_o_tag      = '0;
                        n_o_last     = 1'b1;
                        n_state      = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_SLRD: begin
                sl_wa = f_addr(cur_ch, r_slot);
                if (sl_rd.valid) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_DUP;
                    n_o_seq   = r_seq;
                    n_o_tag   = 16'(r_tag);
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_off_zero && !r_cs.closed && r_limit != 5'd0) begin
                    // The new packet is the head of the run: it is released at once,
                    // so its slot is written back empty.
                    sl_we      = 1'b1;
                    sl_wd      = '{valid: 1'b0, tag: r_tag};
                    n_hold_v   = 1'b1;
                    n_hold_seq = r_cs.exp;
                    n_hold_tag = r_tag;
                    n_cs.exp   = r_cs.exp + 32'd1;
                    n_cs.base  = f_inc(r_cs.base);
                    n_cnt      = 5'd1;
                    if (5'd1 < r_limit) begin
                        sl_ra   = f_addr(cur_ch, n_cs.base);
                        n_state = S_REL;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    sl_we     = 1'b1;
                    sl_wd     = '{valid: 1'b1, tag: r_tag};
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_BUFFERED;
                    n_o_seq   = r_seq;
                    n_o_tag   = 16'(r_tag);
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            S_REL: begin
                // One held delivery is kept back so that the last flag is known
                // before it goes out.
                if (sl_rd.valid) begin
                    if (r_hold_v) begin
                        n_o_valid = 1'b1;
                        n_o_kind  = KIND_DELIVERED;
                        n_o_seq   = r_hold_seq;
                        n_o_tag   = 16'(r_hold_tag);
                    end
                    n_hold_v   = 1'b1;
                    n_hold_seq = r_cs.exp;
                    n_hold_tag = sl_rd.tag;
                    sl_we      = 1'b1;
                    sl_wd      = '{valid: 1'b0, tag: sl_rd.tag};
                    n_cs.exp   = r_cs.exp + 32'd1;
                    n_cs.base  = f_inc(r_cs.base);
                    n_cnt      = r_cnt + 5'd1;
                    if ((r_cnt + 5'd1) < r_limit) begin
                        sl_ra = f_addr(cur_ch, n_cs.base);
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                if (r_hold_v) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_DELIVERED;
                    n_o_seq   = r_hold_seq;
                    n_o_tag   = 16'(r_hold_tag);
                    n_o_last  = (r_cmd == CMD_RECV);
                end
                n_hold_v = 1'b0;
                if (r_cmd == CMD_RECV) begin
                    ch_we   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                ch_we     = 1'b1;
                n_o_valid = 1'b1;
                n_o_kind  = KIND_DRAIN;
                n_o_seq   = r_cs.exp;
                n_o_tag   = '0;
                n_o_last  = 1'b1;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_out_channel = r_o_ch;
    assign o_out_seq     = r_o_seq;
    assign o_out_tag     = r_o_tag;
    assign o_last        = r_o_last;

    // No results while the memories are being cleared.
    `MPRB_ASSERT_SAME(a_no_result_in_clear, r_state == S_CLR, !o_valid, "result during clear")
    // An accepted command always starts with the channel word read.
    `MPRB_ASSERT_NEXT(a_accept_reads_chan, start && !busy, r_state == S_CHRD, "accept without read")
    // A held delivery exists only while a run is being released.
    `MPRB_ASSERT_SAME(a_hold_in_run, r_hold_v, r_state == S_REL || r_state == S_FIN, "stray hold")
    // The last beat of a command is never followed directly by another beat.
    `MPRB_ASSERT_NEXT(a_last_ends_burst, o_valid && o_last, !o_valid, "beat after last")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import mprb_pkg::*;

    localparam int WINDOW = 16;
    localparam int CHANNELS = 8;
    localparam int SLOTS = CHANNELS * WINDOW;
    // The clearing sweep after reset and the longest release are far below this.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles allowed after the last expected beat for anything stray to show up.
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_ITEMS = 245;
    // Room for the beats still owed; one command never owes more than 17.
    localparam int OWED_DEPTH = 64;
    localparam int ROWS_MAX = 32;

    // One result beat as it should appear on the o_ ports.
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  ch;
        logic [31:0] seq;
        logic [15:0] tag;
        logic        last;
    } t_beat;

    // One row of the directed table. Where check is set, the row carries the
    // single beat that the command must produce, typed in by hand.
    typedef struct packed {
        t_cmd        cmd;
        logic [2:0]  ch;
        logic [31:0] seq;
        logic [15:0] tag;
        logic [4:0]  budget;
        bit          check;
        t_kind       want_kind;
        logic [31:0] want_seq;
        logic [15:0] want_tag;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [2:0]  i_channel;
    logic [31:0] i_seq_number;
    logic [15:0] i_payload_tag;
    logic [4:0]  i_budget;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [2:0]  o_out_channel;
    logic [31:0] o_out_seq;
    logic [15:0] o_out_tag;
    logic        o_last;

    multichannel_packet_reorder_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_channel     (i_channel),
        .i_seq_number  (i_seq_number),
        .i_payload_tag (i_payload_tag),
        .i_budget      (i_budget),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_out_channel (o_out_channel),
        .o_out_seq     (o_out_seq),
        .o_out_tag     (o_out_tag),
        .o_last        (o_last)
    );

    // Shadow copy of the per-channel reorder state, advanced at every accepted beat.
    logic [31:0] next_rx_seq [CHANNELS];
    logic [31:0] tx_seq [CHANNELS];
    logic [3:0]  win_base [CHANNELS];
    bit          chan_closed [CHANNELS];
    bit          slot_full [SLOTS];
    logic [15:0] stored_tag [SLOTS];

    // Beats still owed by the block, oldest first, kept in a ring.
    t_beat       owed_beats [OWED_DEPTH];
    int          owed_head;
    int          owed_tail;
    int          owed_count;

    t_stim_row   directed_rows [ROWS_MAX];
    int          row_count;

    // The newest beat of the command being predicted is held back so that the
    // last flag can be set on it once the command is fully worked out.
    t_beat         held_beat;
    bit            record_beats;
    int            item_beats;
    int            longest_burst;

    int  error_count;
    int  items_accepted;
    int  beats_seen;
    int  delivered_seen;
    int  cycle_count;
    bit  quiet_stretch;

    always #10 i_clk = ~i_clk;

    function automatic void flag_error(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("[%0t] error: %s", $time, what);
        end
    endfunction

    function automatic void owe_beat(input t_beat b);
        if (owed_count == OWED_DEPTH) begin
            flag_error("too many beats owed at once");
        end else begin
            owed_beats[owed_tail] = b;
            owed_tail = (owed_tail + 1) % OWED_DEPTH;
            owed_count++;
        end
    endfunction

    function automatic t_beat take_beat();
        t_beat b;
        b = owed_beats[owed_head];
        owed_head = (owed_head + 1) % OWED_DEPTH;
        owed_count--;
        return b;
    endfunction

    function automatic void push_beat(input t_kind kind, input logic [2:0] ch,
                                      input logic [31:0] seq, input logic [15:0] tag);
        if (item_beats > 0 && record_beats) begin
            owe_beat(held_beat);
        end
        held_beat.kind = kind;
        held_beat.ch = ch;
        held_beat.seq = seq;
        held_beat.tag = tag;
        held_beat.last = 1'b0;
        item_beats++;
    endfunction

    // Hands out the in-order run that starts at the window base, stopping at
    // the first empty slot, at the release limit, or at once on a closed channel.
    function automatic void release_in_order(input logic [2:0] ch, input int limit);
        int released;
        int idx;
        released = 0;
        while (released < limit && !chan_closed[ch]) begin
            idx = ch * WINDOW + win_base[ch];
            if (!slot_full[idx]) begin
                break;
            end
            push_beat(KIND_DELIVERED, ch, next_rx_seq[ch], stored_tag[idx]);
            slot_full[idx] = 1'b0;
            next_rx_seq[ch] = next_rx_seq[ch] + 32'd1;
            // The window is 16 slots, so the 4-bit base wraps on its own.
            win_base[ch] = win_base[ch] + 4'd1;
            released++;
        end
    endfunction

    // Works out every beat that one accepted command causes and updates the
    // shadow state. With eight channels the channel index needs no folding.
    function automatic void predict_command(input t_cmd cmd, input logic [2:0] ch,
                                            input logic [31:0] seq, input logic [15:0] tag,
                                            input logic [4:0] budget);
        logic [31:0] offset;
        int          idx;
        int          limit;
        item_beats = 0;
        limit = (budget > MAX_RELEASE) ? int'(MAX_RELEASE) : int'(budget);
        case (cmd)
            CMD_RECV: begin
                // Serial arithmetic: a set top bit means the packet is behind us.
                offset = seq - next_rx_seq[ch];
                if (offset[31]) begin
                    push_beat(KIND_OLD_DUP, ch, seq, tag);
                end else if (offset >= WINDOW) begin
                    push_beat(KIND_BEYOND, ch, seq, tag);
                end else begin
                    idx = ch * WINDOW + (int'(win_base[ch]) + int'(offset)) % WINDOW;
                    if (slot_full[idx]) begin
                        push_beat(KIND_DUP, ch, seq, tag);
                    end else begin
                        stored_tag[idx] = tag;
                        slot_full[idx] = 1'b1;
                        if (offset == 0) begin
                            release_in_order(ch, limit);
                        end
                        // A stored packet that released nothing, in order or not, is reported as buffered.
                        if (item_beats == 0) begin
                            push_beat(KIND_BUFFERED, ch, seq, tag);
                        end
                    end
                end
            end
            CMD_DRAIN: begin
                release_in_order(ch, limit);
                push_beat(KIND_DRAIN, ch, next_rx_seq[ch], 16'd0);
            end
            CMD_SEND: begin
                if (chan_closed[ch]) begin
                    push_beat(KIND_CLOSED, ch, 32'd0, 16'd0);
                end else begin
                    push_beat(KIND_ASSIGNED, ch, tx_seq[ch], 16'd0);
                    tx_seq[ch] = tx_seq[ch] + 32'd1;
                end
            end
            default: begin
                chan_closed[ch] = 1'b1;
                push_beat(KIND_CLOSED, ch, 32'd0, 16'd0);
            end
        endcase
        held_beat.last = 1'b1;
        if (record_beats) begin
            owe_beat(held_beat);
        end
        if (item_beats > longest_burst) begin
            longest_burst = item_beats;
        end
    endfunction

    // Presents one command beat, possibly after a short idle stretch, and holds
    // it until the block takes it. The prediction is made at the accepting edge.
    task automatic issue(input t_cmd cmd, input logic [2:0] ch, input logic [31:0] seq,
                         input logic [15:0] tag, input logic [4:0] budget);
        int gap;
        @(negedge i_clk);
        if (!quiet_stretch && $urandom_range(0, 99) < 13) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_channel <= ch;
        i_seq_number <= seq;
        i_payload_tag <= tag;
        i_budget <= budget;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        predict_command(cmd, ch, seq, tag, budget);
        items_accepted++;
    endtask

    task automatic add_row(input t_cmd cmd, input logic [2:0] ch, input logic [31:0] seq,
                           input logic [15:0] tag, input logic [4:0] budget,
                           input bit check, input t_kind want_kind,
                           input logic [31:0] want_seq, input logic [15:0] want_tag);
        t_stim_row row;
        row.cmd = cmd;
        row.ch = ch;
        row.seq = seq;
        row.tag = tag;
        row.budget = budget;
        row.check = check;
        row.want_kind = want_kind;
        row.want_seq = want_seq;
        row.want_tag = want_tag;
        if (row_count < ROWS_MAX) begin
            directed_rows[row_count] = row;
            row_count++;
        end
    endtask

    // Fills offsets 1 to 15 of one channel in a shuffled order, then closes the
    // gap at offset zero. Half the time the run goes out on the arrival itself,
    // otherwise the arrival is held back with a zero budget and a drain with a
    // large budget releases the whole window plus its done beat.
    task automatic fill_window_burst();
        int          order [WINDOW - 1];
        int          i;
        int          pick;
        int          swap;
        logic [2:0]  ch;
        ch = 3'($urandom_range(0, 4));
        for (i = 0; i < WINDOW - 1; i++) begin
            order[i] = i + 1;
        end
        for (i = WINDOW - 2; i > 0; i--) begin
            pick = $urandom_range(0, i);
            swap = order[i];
            order[i] = order[pick];
            order[pick] = swap;
        end
        for (i = 0; i < WINDOW - 1; i++) begin
            issue(CMD_RECV, ch, next_rx_seq[ch] + order[i], 16'($urandom_range(0, 65535)),
                  5'($urandom_range(0, 31)));
        end
        if ($urandom_range(0, 1) == 1) begin
            issue(CMD_RECV, ch, next_rx_seq[ch], 16'($urandom_range(0, 65535)),
                  5'($urandom_range(16, 31)));
        end else begin
            issue(CMD_RECV, ch, next_rx_seq[ch], 16'($urandom_range(0, 65535)), 5'd0);
            issue(CMD_DRAIN, ch, $urandom, 16'($urandom_range(0, 65535)),
                  5'($urandom_range(16, 31)));
        end
    endtask

    // Every beat that the block puts out is matched against the oldest one owed.
    always @(posedge i_clk) begin : check_beats
        t_beat want;
        if (i_rst_n && o_valid) begin
            beats_seen++;
            if (owed_count == 0) begin
                flag_error($sformatf("unexpected beat kind %0d ch %0d seq %h tag %h last %0d",
                                     o_kind, o_out_channel, o_out_seq, o_out_tag, o_last));
            end else begin
                want = take_beat();
                if (o_kind !== want.kind || o_out_channel !== want.ch ||
                        o_out_seq !== want.seq || o_out_tag !== want.tag ||
                        o_last !== want.last) begin
                    flag_error($sformatf({"beat mismatch: kind %0d/%0d ch %0d/%0d ",
                                          "seq %h/%h tag %h/%h last %0d/%0d ",
                                          "(expected/actual)"},
                                         want.kind, o_kind, want.ch, o_out_channel,
                                         want.seq, o_out_seq, want.tag, o_out_tag,
                                         want.last, o_last));
                end else if (want.kind == KIND_DELIVERED) begin
                    delivered_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d beats still owed",
                     cycle_count, owed_count);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        t_stim_row     row;
        t_beat         typed_beat;
        int            r;
        int            roll;
        int            closed_total;
        logic [2:0]    ch;
        logic [31:0]   seq;
        logic [4:0]    budget;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = CMD_RECV;
        i_channel = 3'd0;
        i_seq_number = 32'd0;
        i_payload_tag = 16'd0;
        i_budget = 5'd0;
        record_beats = 1'b1;
        quiet_stretch = 1'b0;
        error_count = 0;
        items_accepted = 0;
        beats_seen = 0;
        delivered_seen = 0;
        cycle_count = 0;
        longest_burst = 0;
        owed_head = 0;
        owed_tail = 0;
        owed_count = 0;
        row_count = 0;
        for (r = 0; r < CHANNELS; r++) begin
            next_rx_seq[r] = 32'd0;
            tx_seq[r] = 32'd0;
            win_base[r] = 4'd0;
            chan_closed[r] = 1'b0;
        end
        for (r = 0; r < SLOTS; r++) begin
            slot_full[r] = 1'b0;
            stored_tag[r] = 16'd0;
        end

        // Directed table. Channel 1 walks through every receive outcome, from
        // the serial-arithmetic extremes to buffering, duplicates, a zero budget
        // and drains with small and over-the-cap budgets. Channel 7 is closed
        // twice and then still takes receives and drains but delivers nothing.
        add_row(CMD_SEND,  3'd0, 32'd0,         16'h0000, 5'd0,  1, KIND_ASSIGNED, 32'd0, 16'h0);
        add_row(CMD_SEND,  3'd0, 32'hFFFFFFFF,  16'hFFFF, 5'd31, 1, KIND_ASSIGNED, 32'd1, 16'h0);
        add_row(CMD_RECV,  3'd1, 32'hFFFFFFFF,  16'hFFFF, 5'd31,
                1, KIND_OLD_DUP, 32'hFFFFFFFF, 16'hFFFF);
        add_row(CMD_RECV,  3'd1, 32'h80000000,  16'h0000, 5'd0,
                1, KIND_OLD_DUP, 32'h80000000, 16'h0000);
        add_row(CMD_RECV,  3'd1, 32'h7FFFFFFF,  16'h5A5A, 5'd16,
                1, KIND_BEYOND, 32'h7FFFFFFF, 16'h5A5A);
        add_row(CMD_RECV,  3'd1, 32'd16,        16'h0000, 5'd16, 1, KIND_BEYOND, 32'd16, 16'h0);
        add_row(CMD_RECV,  3'd1, 32'd15,        16'hAAAA, 5'd0,
                1, KIND_BUFFERED, 32'd15, 16'hAAAA);
        add_row(CMD_RECV,  3'd1, 32'd15,        16'h5555, 5'd31, 1, KIND_DUP, 32'd15, 16'h5555);
        add_row(CMD_RECV,  3'd1, 32'd3,         16'h1234, 5'd5,  0, KIND_DELIVERED, 32'd0, 16'h0);
        add_row(CMD_RECV,  3'd1, 32'd0,         16'h0000, 5'd0,  0, KIND_DELIVERED, 32'd0, 16'h0);
        add_row(CMD_DRAIN, 3'd1, 32'd0,         16'h0000, 5'd0,  0, KIND_DELIVERED, 32'd0, 16'h0);
        add_row(CMD_RECV,  3'd1, 32'd1,         16'hFFFF, 5'd31, 0, KIND_DELIVERED, 32'd0, 16'h0);
        add_row(CMD_RECV,  3'd1, 32'd2,         16'h0F0F, 5'd1,  0, KIND_DELIVERED, 32'd0, 16'h0);
        add_row(CMD_DRAIN, 3'd1, 32'hFFFFFFFF,  16'hFFFF, 5'd2,  0, KIND_DELIVERED, 32'd0, 16'h0);
        add_row(CMD_DRAIN, 3'd1, 32'd0,         16'h0000, 5'd31, 0, KIND_DELIVERED, 32'd0, 16'h0);
        add_row(CMD_RECV,  3'd1, 32'd0,         16'h0101, 5'd31, 0, KIND_DELIVERED, 32'd0, 16'h0);
        add_row(CMD_RECV,  3'd1, 32'd4,         16'hC3C3, 5'd16, 0, KIND_DELIVERED, 32'd0, 16'h0);
        add_row(CMD_CLOSE, 3'd7, 32'd0,         16'h0000, 5'd0,  1, KIND_CLOSED, 32'd0, 16'h0);
        add_row(CMD_CLOSE, 3'd7, 32'hFFFFFFFF,  16'hFFFF, 5'd31, 1, KIND_CLOSED, 32'd0, 16'h0);
        add_row(CMD_SEND,  3'd7, 32'd0,         16'h0000, 5'd0,  1, KIND_CLOSED, 32'd0, 16'h0);
        add_row(CMD_RECV,  3'd7, 32'd0,         16'hBEEF, 5'd31, 0, KIND_DELIVERED, 32'd0, 16'h0);
        add_row(CMD_DRAIN, 3'd7, 32'd0,         16'h0000, 5'd31, 0, KIND_DELIVERED, 32'd0, 16'h0);
        add_row(CMD_RECV,  3'd7, 32'd0,         16'h1111, 5'd31, 0, KIND_DELIVERED, 32'd0, 16'h0);
        add_row(CMD_SEND,  3'd2, 32'd0,         16'h0000, 5'd0,  1, KIND_ASSIGNED, 32'd0, 16'h0);
        add_row(CMD_RECV,  3'd0, 32'd0,         16'h7777, 5'd17, 0, KIND_DELIVERED, 32'd0, 16'h0);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Rows with a typed beat still run through the predictor so that the
        // shadow state stays in step, but only the typed beat is queued.
        for (r = 0; r < row_count; r++) begin
            row = directed_rows[r];
            record_beats = !row.check;
            issue(row.cmd, row.ch, row.seq, row.tag, row.budget);
            if (row.check) begin
                typed_beat.kind = row.want_kind;
                typed_beat.ch = row.ch;
                typed_beat.seq = row.want_seq;
                typed_beat.tag = row.want_tag;
                typed_beat.last = 1'b1;
                owe_beat(typed_beat);
            end
        end
        record_beats = 1'b1;

        // Random part. Most commands are well-formed receives near the window
        // base of channels 0 to 6, so runs build up and get released; the rest
        // are drains, sends, rare closes of channels 5 and 6, packets just
        // outside the window, and fully random noise. Channels 0 to 4 stay
        // open throughout.
        r = 0;
        while (r < RANDOM_ITEMS) begin
            quiet_stretch = (r >= 100 && r < 160);
            roll = $urandom_range(0, 99);
            ch = 3'($urandom_range(0, 6));
            budget = ($urandom_range(0, 99) < 15) ? 5'($urandom_range(17, 31))
                                                  : 5'($urandom_range(0, 16));
            if (roll < 2) begin
                fill_window_burst();
                r += WINDOW;
            end else begin
                if (roll < 60) begin
                    seq = next_rx_seq[ch];
                    if ($urandom_range(0, 99) >= 30) begin
                        seq = seq + $urandom_range(1, WINDOW - 1);
                    end
                    issue(CMD_RECV, ch, seq, 16'($urandom_range(0, 65535)), budget);
                end else if (roll < 70) begin
                    issue(CMD_DRAIN, 3'($urandom_range(0, 7)), $urandom,
                          16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
                end else if (roll < 80) begin
                    issue(CMD_SEND, 3'($urandom_range(0, 7)), $urandom,
                          16'($urandom_range(0, 65535)), budget);
                end else if (roll < 82) begin
                    issue(CMD_CLOSE, 3'($urandom_range(5, 6)), $urandom,
                          16'($urandom_range(0, 65535)), budget);
                end else if (roll < 90) begin
                    if ($urandom_range(0, 1) == 1) begin
                        seq = next_rx_seq[ch] - $urandom_range(1, 3);
                    end else begin
                        seq = next_rx_seq[ch] + $urandom_range(WINDOW, WINDOW + 4);
                    end
                    issue(CMD_RECV, ch, seq, 16'($urandom_range(0, 65535)), budget);
                end else begin
                    // Noise never closes a channel, so the live ones stay live.
                    issue(t_cmd'($urandom_range(0, 2)), 3'($urandom_range(0, 7)), $urandom,
                          16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
                end
                r++;
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (owed_count != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        closed_total = 0;
        for (r = 0; r < CHANNELS; r++) begin
            closed_total += chan_closed[r];
        end
        $display("Ran %0d commands (%0d from the directed table) giving %0d result beats,",
                 items_accepted, row_count, beats_seen);
        $display("%0d packets delivered in order, longest command %0d beats, %0d channels closed.",
                 delivered_seen, longest_burst, closed_total);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d errors in total", error_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mprb_pkg.sv
hw/rtl/mprb_ram.sv
hw/rtl/multichannel_packet_reorder_buffer.sv
tb/testbench.sv
